### hw/rtl/abq_pkg.sv
// abq_pkg: shared types and constants of the aging byte-budget queue
// used by abq_ctrl, abq_dp and the top level; no dependencies
`default_nettype none

package abq_pkg;

    // payload field widths
    localparam int HANDLE_W     = 32;
    localparam int BYTES_W      = 24;
    localparam int STAMP_W      = 32;
    localparam int AGE_W        = 16;
    localparam int ENT_W        = 7;
    localparam int CMD_W        = 2;
    localparam int STEP_CNT_W   = 7;
    localparam int STEP_BYTES_W = 25;
    localparam int TOTAL_W      = 48;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = 2'd2;

    localparam logic [ENT_W-1:0]   RST_MAX_ENTRIES = 7'd64;
    localparam logic [BYTES_W-1:0] RST_MAX_BYTES   = 24'd8388608;
    localparam logic [AGE_W-1:0]   RST_MAX_AGE     = 16'd5;

    // operation codes on the cmd field
    typedef enum logic [CMD_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2,
        OP_NOP = 2'd3
    } t_abq_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AGE,
        S_EVICT,
        S_DONE
    } t_abq_state;

    // one queue entry as stored in the memory
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  size;
        logic [STAMP_W-1:0]  stamp;
    } t_abq_entry;

    // controller to datapath
    typedef struct packed {
        logic accept;     // latch a new item
        logic clear_q;    // empty the queue
        logic drop_head;  // drop the head entry (aged or evicted)
        logic deq;        // pop the head entry as the result
        logic push;       // write the new entry at the tail
        logic oversize;   // drop the new entry itself
        logic load_out;   // load the output register
    } t_abq_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_entry;
        logic expired;
        logic need_evict;
        logic oversize;
    } t_abq_stat;

endpackage

`default_nettype wire

### hw/rtl/abq_ctrl.sv
// abq_ctrl: sequencer of the aging byte-budget queue
// depends on abq_pkg; drives abq_dp through t_abq_cmd, reads t_abq_stat
`default_nettype none

module abq_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire [abq_pkg::CMD_W-1:0] i_cmd,
    input  wire                      i_msg_present,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    input  abq_pkg::t_abq_stat       i_stat,
    output abq_pkg::t_abq_cmd        o_cmd
);

    abq_pkg::t_abq_state r_state, n_state;
    abq_pkg::t_abq_op    r_op, n_op;
    abq_pkg::t_abq_op    in_op;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                accept_ok;
    logic                fire;

    assign in_op    = abq_pkg::t_abq_op'(i_cmd);
    assign out_free = !r_out_valid || i_out_ready;

    // state, latched operation and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= abq_pkg::S_IDLE;
            r_op        <= abq_pkg::OP_NOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_cmd       = '0;
        accept_ok   = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            abq_pkg::S_IDLE: begin
                accept_ok = 1'b1;
            end
            abq_pkg::S_AGE: begin
                if (i_stat.expired) begin
                    o_cmd.drop_head = 1'b1;
                end else if (r_op == abq_pkg::OP_DEQ) begin
                    o_cmd.deq = i_stat.has_entry;
                    n_state   = abq_pkg::S_DONE;
                end else if (i_stat.oversize) begin
                    o_cmd.oversize = 1'b1;
                    n_state        = abq_pkg::S_DONE;
                end else if (i_stat.need_evict) begin
                    o_cmd.drop_head = 1'b1;
                    n_state         = abq_pkg::S_EVICT;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = abq_pkg::S_DONE;
                end
            end
            abq_pkg::S_EVICT: begin
                if (i_stat.need_evict) begin
                    o_cmd.drop_head = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = abq_pkg::S_DONE;
                end
            end
            abq_pkg::S_DONE: begin
                // result goes out once the output register is free
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = abq_pkg::S_IDLE;
                    accept_ok      = 1'b1;
                end
            end
            default: begin
                n_state = abq_pkg::S_IDLE;
            end
        endcase

        // take a new item
        fire = i_in_valid && accept_ok;
        if (fire) begin
            o_cmd.accept  = 1'b1;
            o_cmd.clear_q = (in_op == abq_pkg::OP_CLR);
            n_op          = in_op;
            if ((in_op == abq_pkg::OP_ENQ && i_msg_present) || in_op == abq_pkg::OP_DEQ) begin
                n_state = abq_pkg::S_AGE;
            end else begin
                n_state = abq_pkg::S_DONE;
            end
        end
    end

    assign o_in_ready  = accept_ok;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hw/rtl/abq_dp.sv
// abq_dp: datapath of the aging byte-budget queue: entry memory, pointers,
// byte and drop accounting, configuration and output registers; uses abq_pkg
`default_nettype none

module abq_dp #(
    parameter int DEPTH = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_valid,
    input  wire [abq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [abq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // item fields
    input  wire [abq_pkg::HANDLE_W-1:0]     i_msg_handle,
    input  wire [abq_pkg::BYTES_W-1:0]      i_msg_bytes,
    input  wire [abq_pkg::STAMP_W-1:0]      i_msg_stamp,
    input  wire [abq_pkg::STAMP_W-1:0]      i_now_time,
    // control
    input  abq_pkg::t_abq_cmd               i_cmd,
    output abq_pkg::t_abq_stat              o_stat,
    // result fields
    output logic                            o_done_res,
    output logic [abq_pkg::HANDLE_W-1:0]    o_out_handle,
    output logic [abq_pkg::BYTES_W-1:0]     o_out_bytes,
    output logic [abq_pkg::STAMP_W-1:0]     o_out_stamp,
    output logic [abq_pkg::STEP_CNT_W-1:0]  o_step_drop_count,
    output logic [abq_pkg::STEP_BYTES_W-1:0] o_step_drop_bytes,
    output logic                            o_oversize_drop,
    output logic [abq_pkg::ENT_W-1:0]       o_queue_count,
    output logic [abq_pkg::BYTES_W-1:0]     o_queue_bytes,
    output logic [abq_pkg::TOTAL_W-1:0]     o_total_drop_count,
    output logic [abq_pkg::TOTAL_W-1:0]     o_total_drop_bytes
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > abq_pkg::ENT_W) ? CW : abq_pkg::ENT_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

    // configuration registers
    logic [abq_pkg::ENT_W-1:0]   r_max_entries;
    logic [abq_pkg::BYTES_W-1:0] r_max_bytes;
    logic [abq_pkg::AGE_W-1:0]   r_max_age;

    // queue state
    abq_pkg::t_abq_entry r_mem [DEPTH];
    abq_pkg::t_abq_entry r_rd;
    logic [AW-1:0]               r_head, n_head;
    logic [AW-1:0]               r_tail, n_tail;
    logic [CW-1:0]               r_count, n_count;
    logic [abq_pkg::BYTES_W-1:0] r_bytes, n_bytes;
    logic [abq_pkg::TOTAL_W-1:0] r_tot_cnt, n_tot_cnt;
    logic [abq_pkg::TOTAL_W-1:0] r_tot_bytes, n_tot_bytes;

    // per-item registers
    logic [abq_pkg::HANDLE_W-1:0]     r_handle;
    logic [abq_pkg::BYTES_W-1:0]      r_msg_bytes;
    logic [abq_pkg::STAMP_W-1:0]      r_stamp;
    logic [abq_pkg::STAMP_W-1:0]      r_now;
    logic [abq_pkg::BYTES_W-1:0]      r_room;
    logic                             r_over;
    logic                             r_done;
    logic                             r_over_drop;
    logic [abq_pkg::HANDLE_W-1:0]     r_deq_handle;
    logic [abq_pkg::BYTES_W-1:0]      r_deq_bytes;
    logic [abq_pkg::STAMP_W-1:0]      r_deq_stamp;
    logic [abq_pkg::STEP_CNT_W-1:0]   r_step_cnt;
    logic [abq_pkg::STEP_BYTES_W-1:0] r_step_bytes;

    // output register
    logic                             r_o_done;
    logic [abq_pkg::HANDLE_W-1:0]     r_o_handle;
    logic [abq_pkg::BYTES_W-1:0]      r_o_bytes;
    logic [abq_pkg::STAMP_W-1:0]      r_o_stamp;
    logic [abq_pkg::STEP_CNT_W-1:0]   r_o_step_cnt;
    logic [abq_pkg::STEP_BYTES_W-1:0] r_o_step_bytes;
    logic                             r_o_over;
    logic [abq_pkg::ENT_W-1:0]        r_o_count;
    logic [abq_pkg::BYTES_W-1:0]      r_o_qbytes;
    logic [abq_pkg::TOTAL_W-1:0]      r_o_tot_cnt;
    logic [abq_pkg::TOTAL_W-1:0]      r_o_tot_bytes;

    logic                             pop;
    logic [AW-1:0]                    head_inc;
    logic [AW-1:0]                    tail_inc;
    logic [abq_pkg::STAMP_W-1:0]      age;
    logic [LW-1:0]                    max_e_l;
    logic [LW-1:0]                    limit;
    logic [LW-1:0]                    count_l;
    logic                             has_entry;
    logic [abq_pkg::BYTES_W-1:0]      drop_sz;
    logic [abq_pkg::TOTAL_W:0]        sum_cnt;
    logic [abq_pkg::TOTAL_W:0]        sum_bytes;

    // configuration writes; an unknown index writes nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= abq_pkg::RST_MAX_ENTRIES;
            r_max_bytes   <= abq_pkg::RST_MAX_BYTES;
            r_max_age     <= abq_pkg::RST_MAX_AGE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                abq_pkg::CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[abq_pkg::ENT_W-1:0];
                abq_pkg::CFG_MAX_BYTES:   r_max_bytes   <= i_cfg_data[abq_pkg::BYTES_W-1:0];
                abq_pkg::CFG_MAX_AGE:     r_max_age     <= i_cfg_data[abq_pkg::AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // head checks against the registered head entry
    assign has_entry = (r_count != '0);
    assign age       = r_now - r_rd.stamp;
    assign max_e_l   = LW'(r_max_entries);
    assign limit     = (max_e_l > DEPTH_L) ? DEPTH_L : max_e_l;
    assign count_l   = LW'(r_count);

    assign o_stat.has_entry  = has_entry;
    assign o_stat.expired    = has_entry && (age >= abq_pkg::STAMP_W'(r_max_age));
    assign o_stat.need_evict = has_entry && ((count_l >= limit) || (r_bytes > r_room));
    assign o_stat.oversize   = r_over;

    // pointer, count and byte updates
    assign pop      = i_cmd.drop_head || i_cmd.deq;
    assign head_inc = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST) ? '0 : r_tail + 1'b1;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_bytes = r_bytes;
        if (i_cmd.clear_q) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
            n_bytes = '0;
        end else if (pop) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
            n_bytes = (r_rd.size > r_bytes) ? '0 : r_bytes - r_rd.size;
        end else if (i_cmd.push) begin
            n_tail  = tail_inc;
            n_count = r_count + 1'b1;
            n_bytes = r_bytes + r_msg_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_bytes <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_bytes <= n_bytes;
        end
    end

    // entry memory; the read follows the next head so the new head entry is
    // ready in the cycle after a pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= '{handle: r_handle, size: r_msg_bytes, stamp: r_stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[n_head];
    end

    // item latch and per-item results
    assign drop_sz = i_cmd.oversize ? r_msg_bytes : r_rd.size;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_handle     <= i_msg_handle;
            r_msg_bytes  <= i_msg_bytes;
            r_stamp      <= i_msg_stamp;
            r_now        <= i_now_time;
            r_over       <= (i_msg_bytes > r_max_bytes);
            r_room       <= r_max_bytes - i_msg_bytes;
            r_done       <= 1'b0;
            r_over_drop  <= 1'b0;
            r_deq_handle <= '0;
            r_deq_bytes  <= '0;
            r_deq_stamp  <= '0;
            r_step_cnt   <= '0;
            r_step_bytes <= '0;
        end else begin
            // dropped entry, aged, evicted or oversize
            if (i_cmd.drop_head || i_cmd.oversize) begin
                if (r_step_cnt != '1) begin
                    r_step_cnt <= r_step_cnt + 1'b1;
                end
                r_step_bytes <= r_step_bytes + abq_pkg::STEP_BYTES_W'(drop_sz);
            end
            if (i_cmd.oversize) begin
                r_over_drop <= 1'b1;
            end
            if (i_cmd.push) begin
                r_done <= 1'b1;
            end
            if (i_cmd.deq) begin
                r_done       <= 1'b1;
                r_deq_handle <= r_rd.handle;
                r_deq_bytes  <= r_rd.size;
                r_deq_stamp  <= r_rd.stamp;
            end
        end
    end

    // saturating drop totals
    assign sum_cnt   = {1'b0, r_tot_cnt} + (abq_pkg::TOTAL_W + 1)'(r_step_cnt);
    assign sum_bytes = {1'b0, r_tot_bytes} + (abq_pkg::TOTAL_W + 1)'(r_step_bytes);
    assign n_tot_cnt = sum_cnt[abq_pkg::TOTAL_W] ? '1 : sum_cnt[abq_pkg::TOTAL_W-1:0];
    assign n_tot_bytes = sum_bytes[abq_pkg::TOTAL_W] ? '1 : sum_bytes[abq_pkg::TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_cnt   <= '0;
            r_tot_bytes <= '0;
        end else if (i_cmd.load_out) begin
            r_tot_cnt   <= n_tot_cnt;
            r_tot_bytes <= n_tot_bytes;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_done       <= r_done;
            r_o_handle     <= r_deq_handle;
            r_o_bytes      <= r_deq_bytes;
            r_o_stamp      <= r_deq_stamp;
            r_o_step_cnt   <= r_step_cnt;
            r_o_step_bytes <= r_step_bytes;
            r_o_over       <= r_over_drop;
            r_o_count      <= count_l[abq_pkg::ENT_W-1:0];
            r_o_qbytes     <= r_bytes;
            r_o_tot_cnt    <= n_tot_cnt;
            r_o_tot_bytes  <= n_tot_bytes;
        end
    end

    assign o_done_res         = r_o_done;
    assign o_out_handle       = r_o_handle;
    assign o_out_bytes        = r_o_bytes;
    assign o_out_stamp        = r_o_stamp;
    assign o_step_drop_count  = r_o_step_cnt;
    assign o_step_drop_bytes  = r_o_step_bytes;
    assign o_oversize_drop    = r_o_over;
    assign o_queue_count      = r_o_count;
    assign o_queue_bytes      = r_o_qbytes;
    assign o_total_drop_count = r_o_tot_cnt;
    assign o_total_drop_bytes = r_o_tot_bytes;

endmodule

`default_nettype wire

### hw/rtl/aging_byte_budget_drop_oldest_queue_core.sv
// Descriptor queue with a count limit, a byte budget and a time-to-live on
// each entry. Every item produces one result item. An enqueue or dequeue ages
// expired entries off the head; an enqueue drops itself if oversize, else
// evicts from the head until both limits admit it and pushes; a dequeue pops.
// Clear, null and unused commands skip this. Entries leave the head one per
// cycle through the registered read port. A new item is taken in the cycle its
// predecessor's result enters the output register; a finished item whose
// result finds that register still occupied holds the block until the waiting
// result is taken. Configuration writes are taken at any time and must only be
// issued while the block is idle. No clearing pass after reset.
//
// top level: instantiates abq_ctrl and abq_dp, uses abq_pkg
`default_nettype none

module aging_byte_budget_drop_oldest_queue_core #(
    parameter int DEPTH = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration channel
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [abq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [abq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [abq_pkg::CMD_W-1:0]          i_cmd,
    input  wire                               i_msg_present,
    input  wire [abq_pkg::HANDLE_W-1:0]       i_msg_handle,
    input  wire [abq_pkg::BYTES_W-1:0]        i_msg_bytes,
    input  wire [abq_pkg::STAMP_W-1:0]        i_msg_stamp,
    input  wire [abq_pkg::STAMP_W-1:0]        i_now_time,
    // result items
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic                              o_done_res,
    output logic [abq_pkg::HANDLE_W-1:0]      o_out_handle,
    output logic [abq_pkg::BYTES_W-1:0]       o_out_bytes,
    output logic [abq_pkg::STAMP_W-1:0]       o_out_stamp,
    output logic [abq_pkg::STEP_CNT_W-1:0]    o_step_drop_count,
    output logic [abq_pkg::STEP_BYTES_W-1:0]  o_step_drop_bytes,
    output logic                              o_oversize_drop,
    output logic [abq_pkg::ENT_W-1:0]         o_queue_count,
    output logic [abq_pkg::BYTES_W-1:0]       o_queue_bytes,
    output logic [abq_pkg::TOTAL_W-1:0]       o_total_drop_count,
    output logic [abq_pkg::TOTAL_W-1:0]       o_total_drop_bytes
);

    abq_pkg::t_abq_cmd  cmd;
    abq_pkg::t_abq_stat stat;

    // configuration writes complete at once
    assign o_cfg_ready = 1'b1;

    abq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_msg_present (i_msg_present),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    abq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_msg_handle       (i_msg_handle),
        .i_msg_bytes        (i_msg_bytes),
        .i_msg_stamp        (i_msg_stamp),
        .i_now_time         (i_now_time),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_done_res         (o_done_res),
        .o_out_handle       (o_out_handle),
        .o_out_bytes        (o_out_bytes),
        .o_out_stamp        (o_out_stamp),
        .o_step_drop_count  (o_step_drop_count),
        .o_step_drop_bytes  (o_step_drop_bytes),
        .o_oversize_drop    (o_oversize_drop),
        .o_queue_count      (o_queue_count),
        .o_queue_bytes      (o_queue_bytes),
        .o_total_drop_count (o_total_drop_count),
        .o_total_drop_bytes (o_total_drop_bytes)
    );

endmodule

`default_nettype wire

### hw/rtl/abq_chk.sv
// abq_chk: port-level checks of the aging byte-budget queue, bound to
// aging_byte_budget_drop_oldest_queue_core; uses abq_pkg for widths
`default_nettype none

module abq_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire                               o_done_res,
    input wire [abq_pkg::HANDLE_W-1:0]       o_out_handle,
    input wire [abq_pkg::BYTES_W-1:0]        o_out_bytes,
    input wire [abq_pkg::STAMP_W-1:0]        o_out_stamp,
    input wire [abq_pkg::STEP_CNT_W-1:0]     o_step_drop_count,
    input wire [abq_pkg::STEP_BYTES_W-1:0]   o_step_drop_bytes,
    input wire                               o_oversize_drop,
    input wire [abq_pkg::TOTAL_W-1:0]        o_total_drop_count
);

    // a waiting result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its total drop count
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_total_drop_count))
        else $error("result changed while stalled");

    // an oversize enqueue is not accepted and counts as a drop
    a_oversize: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_oversize_drop |-> !o_done_res && o_step_drop_count != '0)
        else $error("oversize drop not accounted");

    // no dropped entry means no dropped bytes
    a_drop_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_step_drop_count == '0 |-> o_step_drop_bytes == '0)
        else $error("bytes dropped without an entry");

    // fields of a dequeued entry are zero when nothing was returned
    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |->
            o_out_handle == '0 && o_out_bytes == '0 && o_out_stamp == '0)
        else $error("entry fields set without a result");

endmodule

bind aging_byte_budget_drop_oldest_queue_core abq_chk u_abq_chk (.*);

`default_nettype wire

### dv/aging_byte_budget_drop_oldest_queue_core_tb.sv
// self-checking testbench for the aging byte-budget drop-oldest queue core
// predicts each result item from its own queue model, depends on abq_pkg and the core
`timescale 1ns / 100ps

module aging_byte_budget_drop_oldest_queue_core_tb;

    localparam int HANDLE_W     = abq_pkg::HANDLE_W;
    localparam int BYTES_W      = abq_pkg::BYTES_W;
    localparam int STAMP_W      = abq_pkg::STAMP_W;
    localparam int AGE_W        = abq_pkg::AGE_W;
    localparam int ENT_W        = abq_pkg::ENT_W;
    localparam int CMD_W        = abq_pkg::CMD_W;
    localparam int STEP_CNT_W   = abq_pkg::STEP_CNT_W;
    localparam int STEP_BYTES_W = abq_pkg::STEP_BYTES_W;
    localparam int TOTAL_W      = abq_pkg::TOTAL_W;
    localparam int CFG_IDX_W    = abq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = abq_pkg::CFG_DATA_W;

    localparam int QDEPTH      = 64;
    localparam int HEAD_W      = 6;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 2000000;

    // one request item as it is driven
    typedef struct packed {
        abq_pkg::t_abq_op    cmd;
        logic                present;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  size;
        logic [STAMP_W-1:0]  stamp;
        logic [STAMP_W-1:0]  now;
    } t_queue_request;

    // one result item as it is expected
    typedef struct packed {
        logic                    done;
        logic [HANDLE_W-1:0]     handle;
        logic [BYTES_W-1:0]      size;
        logic [STAMP_W-1:0]      stamp;
        logic [STEP_CNT_W-1:0]   drop_cnt;
        logic [STEP_BYTES_W-1:0] drop_bytes;
        logic                    oversize;
        logic [ENT_W-1:0]        count;
        logic [BYTES_W-1:0]      bytes;
        logic [TOTAL_W-1:0]      total_cnt;
        logic [TOTAL_W-1:0]      total_bytes;
    } t_queue_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_cmd;
    logic                    i_msg_present;
    logic [HANDLE_W-1:0]     i_msg_handle;
    logic [BYTES_W-1:0]      i_msg_bytes;
    logic [STAMP_W-1:0]      i_msg_stamp;
    logic [STAMP_W-1:0]      i_now_time;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_done_res;
    logic [HANDLE_W-1:0]     o_out_handle;
    logic [BYTES_W-1:0]      o_out_bytes;
    logic [STAMP_W-1:0]      o_out_stamp;
    logic [STEP_CNT_W-1:0]   o_step_drop_count;
    logic [STEP_BYTES_W-1:0] o_step_drop_bytes;
    logic                    o_oversize_drop;
    logic [ENT_W-1:0]        o_queue_count;
    logic [BYTES_W-1:0]      o_queue_bytes;
    logic [TOTAL_W-1:0]      o_total_drop_count;
    logic [TOTAL_W-1:0]      o_total_drop_bytes;

    // queue model state
    logic [HANDLE_W-1:0]     q_handle [QDEPTH];
    logic [BYTES_W-1:0]      q_size   [QDEPTH];
    logic [STAMP_W-1:0]      q_stamp  [QDEPTH];
    logic [HEAD_W-1:0]       q_head;
    logic [ENT_W-1:0]        q_count;
    logic [BYTES_W-1:0]      q_bytes;
    logic [TOTAL_W-1:0]      total_cnt;
    logic [TOTAL_W-1:0]      total_bytes;
    logic [STEP_CNT_W-1:0]   step_cnt;
    logic [STEP_BYTES_W-1:0] step_bytes;

    // limits as last written
    logic [ENT_W-1:0]        lim_entries;
    logic [BYTES_W-1:0]      lim_bytes;
    logic [AGE_W-1:0]        lim_age;

    t_queue_outcome          expected_outcomes [$];
    logic [STAMP_W-1:0]      wall_time;
    bit                      no_idle;
    int unsigned             mismatches;
    int unsigned             items_sent;
    int unsigned             results_checked;
    int unsigned             settings_used;
    int unsigned             cycles;

    aging_byte_budget_drop_oldest_queue_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_msg_present      (i_msg_present),
        .i_msg_handle       (i_msg_handle),
        .i_msg_bytes        (i_msg_bytes),
        .i_msg_stamp        (i_msg_stamp),
        .i_now_time         (i_now_time),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_done_res         (o_done_res),
        .o_out_handle       (o_out_handle),
        .o_out_bytes        (o_out_bytes),
        .o_out_stamp        (o_out_stamp),
        .o_step_drop_count  (o_step_drop_count),
        .o_step_drop_bytes  (o_step_drop_bytes),
        .o_oversize_drop    (o_oversize_drop),
        .o_queue_count      (o_queue_count),
        .o_queue_bytes      (o_queue_bytes),
        .o_total_drop_count (o_total_drop_count),
        .o_total_drop_bytes (o_total_drop_bytes)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_outcomes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // queue model
    // ---------------------------------------------------------------

    function automatic logic [TOTAL_W-1:0] sat48(input logic [TOTAL_W-1:0] a,
                                                 input logic [STEP_BYTES_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    // count one dropped entry of the given size, count saturates
    function automatic void count_drop(input logic [BYTES_W-1:0] sz);
        if (step_cnt != {STEP_CNT_W{1'b1}})
            step_cnt = step_cnt + 1'b1;
        step_bytes = step_bytes + STEP_BYTES_W'(sz);
    endfunction

    // remove the head entry, byte total floors at zero
    function automatic void pop_head_entry();
        logic [BYTES_W-1:0] sz;
        sz = q_size[q_head];
        q_bytes = (sz > q_bytes) ? '0 : q_bytes - sz;
        q_head  = q_head + 1'b1;
        q_count = q_count - 1'b1;
    endfunction

    function automatic void drop_head_entry();
        count_drop(q_size[q_head]);
        pop_head_entry();
    endfunction

    // drop head entries whose modulo age reached the limit
    function automatic void age_out_entries(input logic [STAMP_W-1:0] now);
        logic [STAMP_W-1:0] age;
        bit                 aging;
        aging = 1'b1;
        while (aging && q_count != 0) begin
            age = now - q_stamp[q_head];
            if (age < STAMP_W'(lim_age))
                aging = 1'b0;
            else
                drop_head_entry();
        end
    endfunction

    function automatic t_queue_outcome predict_outcome(input t_queue_request req);
        t_queue_outcome     res;
        logic [ENT_W-1:0]   cap;
        logic [BYTES_W-1:0] room;
        logic [HEAD_W-1:0]  slot;
        res        = '0;
        step_cnt   = '0;
        step_bytes = '0;
        case (req.cmd)
            abq_pkg::OP_ENQ: if (req.present) begin
                age_out_entries(req.now);
                if (req.size > lim_bytes) begin
                    // message bigger than the whole budget is itself dropped
                    count_drop(req.size);
                    res.oversize = 1'b1;
                end else begin
                    // evict oldest until both limits admit the new entry
                    cap  = (lim_entries > ENT_W'(QDEPTH)) ? ENT_W'(QDEPTH) : lim_entries;
                    room = lim_bytes - req.size;
                    while (q_count != 0 && (q_count >= cap || q_bytes > room))
                        drop_head_entry();
                    slot = q_head + q_count[HEAD_W-1:0];
                    q_handle[slot] = req.handle;
                    q_size[slot]   = req.size;
                    q_stamp[slot]  = req.stamp;
                    q_count  = q_count + 1'b1;
                    q_bytes  = q_bytes + req.size;
                    res.done = 1'b1;
                end
                total_cnt   = sat48(total_cnt, STEP_BYTES_W'(step_cnt));
                total_bytes = sat48(total_bytes, step_bytes);
            end
            abq_pkg::OP_DEQ: begin
                age_out_entries(req.now);
                total_cnt   = sat48(total_cnt, STEP_BYTES_W'(step_cnt));
                total_bytes = sat48(total_bytes, step_bytes);
                if (q_count != 0) begin
                    res.done   = 1'b1;
                    res.handle = q_handle[q_head];
                    res.size   = q_size[q_head];
                    res.stamp  = q_stamp[q_head];
                    pop_head_entry();
                end
            end
            abq_pkg::OP_CLR: begin
                q_head  = '0;
                q_count = '0;
                q_bytes = '0;
            end
            // unused command does nothing
            default: ;
        endcase
        res.drop_cnt    = step_cnt;
        res.drop_bytes  = step_bytes;
        res.count       = q_count;
        res.bytes       = q_bytes;
        res.total_cnt   = total_cnt;
        res.total_bytes = total_bytes;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    function automatic t_queue_request make_request(input abq_pkg::t_abq_op cmd,
                                                    input logic present,
                                                    input logic [HANDLE_W-1:0] handle,
                                                    input logic [BYTES_W-1:0] size,
                                                    input logic [STAMP_W-1:0] stamp,
                                                    input logic [STAMP_W-1:0] now);
        t_queue_request req;
        req.cmd     = cmd;
        req.present = present;
        req.handle  = handle;
        req.size    = size;
        req.stamp   = stamp;
        req.now     = now;
        return req;
    endfunction

    // send one item, then record its expected result
    task automatic send_request(input t_queue_request req);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= req.cmd;
        i_msg_present <= req.present;
        i_msg_handle  <= req.handle;
        i_msg_bytes   <= req.size;
        i_msg_stamp   <= req.stamp;
        i_now_time    <= req.now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_outcomes.push_back(predict_outcome(req));
        items_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // write all three limits, only while the block is idle
    task automatic set_limits(input logic [ENT_W-1:0] ent, input logic [BYTES_W-1:0] budget,
                              input logic [AGE_W-1:0] age);
        write_register(abq_pkg::CFG_MAX_ENTRIES, CFG_DATA_W'(ent));
        lim_entries = ent;
        write_register(abq_pkg::CFG_MAX_BYTES, CFG_DATA_W'(budget));
        lim_bytes = budget;
        write_register(abq_pkg::CFG_MAX_AGE, CFG_DATA_W'(age));
        lim_age = age;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // stop sending and wait until every result item is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side stalls before each item
    initial begin
        int unsigned stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] expv,
                               input logic [TOTAL_W-1:0] actv);
        if (actv !== expv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_queue_outcome exp_o;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                exp_o = expected_outcomes.pop_front();
                check_field("done_res", TOTAL_W'(exp_o.done), TOTAL_W'(o_done_res));
                check_field("out_handle", TOTAL_W'(exp_o.handle), TOTAL_W'(o_out_handle));
                check_field("out_bytes", TOTAL_W'(exp_o.size), TOTAL_W'(o_out_bytes));
                check_field("out_stamp", TOTAL_W'(exp_o.stamp), TOTAL_W'(o_out_stamp));
                check_field("step_drop_count", TOTAL_W'(exp_o.drop_cnt),
                            TOTAL_W'(o_step_drop_count));
                check_field("step_drop_bytes", TOTAL_W'(exp_o.drop_bytes),
                            TOTAL_W'(o_step_drop_bytes));
                check_field("oversize_drop", TOTAL_W'(exp_o.oversize),
                            TOTAL_W'(o_oversize_drop));
                check_field("queue_count", TOTAL_W'(exp_o.count), TOTAL_W'(o_queue_count));
                check_field("queue_bytes", TOTAL_W'(exp_o.bytes), TOTAL_W'(o_queue_bytes));
                check_field("total_drop_count", exp_o.total_cnt,   o_total_drop_count);
                check_field("total_drop_bytes", exp_o.total_bytes, o_total_drop_bytes);
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // order, exact budget fit and byte eviction under the reset limits
    task automatic test_fifo_order();
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h0, 24'd0, 32'd0, 32'd0));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'hFFFF_FFFF, 24'd8388608,
                                  32'd1, 32'd1));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'hA5A5_5A5A, 24'd1,
                                  32'd2, 32'd2));
        send_request(make_request(abq_pkg::OP_DEQ, 1'b0, 32'h0, 24'd0, 32'd0, 32'd2));
        send_request(make_request(abq_pkg::OP_DEQ, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                  32'hFFFF_FFFF, 32'd2));
    endtask

    // null enqueue, unused command and clear
    task automatic test_null_nop_clear();
        send_request(make_request(abq_pkg::OP_ENQ, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                  32'hFFFF_FFFF, 32'd3));
        send_request(make_request(abq_pkg::OP_NOP, 1'b1, 32'h1234_5678, 24'h00_0010,
                                  32'd3, 32'd3));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'd1, 24'd10, 32'd3, 32'd3));
        send_request(make_request(abq_pkg::OP_CLR, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(abq_pkg::OP_DEQ, 1'b0, 32'h0, 24'd0, 32'd0, 32'd3));
    endtask

    // messages bigger than the budget
    task automatic test_oversize();
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h0000_0002, 24'd8388609,
                                  32'd4, 32'd4));
    endtask

    // age-out at the limit and across the time wrap
    task automatic test_aging();
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h11, 24'd7, 32'hFFFF_FFFC,
                                  32'hFFFF_FFFC));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h22, 24'd9, 32'hFFFF_FFFE,
                                  32'hFFFF_FFFF));
        send_request(make_request(abq_pkg::OP_DEQ, 1'b0, 32'h0, 24'd0, 32'd0, 32'd1));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h33, 24'd5, 32'd100, 32'd200));
        send_request(make_request(abq_pkg::OP_DEQ, 1'b0, 32'h0, 24'd0, 32'd0, 32'd200));
    endtask

    // count limit of two, then zero which acts like one
    task automatic test_count_limit();
        drain_results();
        set_limits(7'd2, 24'hFF_FFFF, 16'hFFFF);
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h101, 24'd1, 32'd1000,
                                  32'd1000));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h102, 24'd2, 32'd1000,
                                  32'd1000));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h103, 24'd3, 32'd1001,
                                  32'd1001));
        drain_results();
        set_limits(7'd0, 24'hFF_FFFF, 16'hFFFF);
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h104, 24'd4, 32'd1002,
                                  32'd1002));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h105, 24'd5, 32'd1002,
                                  32'd1002));
    endtask

    // zero budget and zero age limit, count limit above the depth
    task automatic test_zero_limits();
        drain_results();
        set_limits(7'd127, 24'd0, 16'd0);
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h201, 24'd0, 32'd2000,
                                  32'd2000));
        send_request(make_request(abq_pkg::OP_ENQ, 1'b1, 32'h202, 24'd1, 32'd2000,
                                  32'd2000));
        send_request(make_request(abq_pkg::OP_DEQ, 1'b0, 32'h0, 24'd0, 32'd0, 32'd2000));
    endtask

    // one setting of the limits and a stream of random items
    task automatic random_phase(input logic [ENT_W-1:0] ent, input logic [BYTES_W-1:0] budget,
                                input logic [AGE_W-1:0] age, input int n,
                                input int unsigned enq_w, input bit quiet);
        t_queue_request req;
        int unsigned    pick;
        drain_results();
        set_limits(ent, budget, age);
        no_idle = quiet;
        for (int i = 0; i < n; i++) begin
            // time mostly creeps forward, now and then jumps anywhere
            if ($urandom_range(0, 99) == 0)
                wall_time = $urandom;
            else
                wall_time = wall_time + $urandom_range(0, 2);
            req.now     = wall_time;
            req.handle  = $urandom;
            req.size    = BYTES_W'($urandom);
            req.stamp   = $urandom;
            req.present = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < enq_w) begin
                req.cmd     = abq_pkg::OP_ENQ;
                req.present = 1'b1;
                // sizes: mostly small, some up to the budget, some oversize
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    req.size = BYTES_W'($urandom_range(0, budget / 64));
                else if (pick < 16)
                    req.size = BYTES_W'($urandom_range(0, budget));
                else if (pick == 18 || budget == {BYTES_W{1'b1}})
                    req.size = budget;
                else if (pick == 19)
                    req.size = budget + 1'b1;
                // stamps: mostly recent, a few in the future or anywhere
                pick = $urandom_range(0, 15);
                if (pick == 1)
                    req.stamp = wall_time + $urandom_range(1, 3);
                else if (pick != 0)
                    req.stamp = wall_time - $urandom_range(0, 6);
            end else if (pick < enq_w + 3) begin
                req.cmd     = abq_pkg::OP_ENQ;
                req.present = 1'b0;
            end else if (pick < enq_w + 5) begin
                req.cmd = abq_pkg::OP_NOP;
            end else if (pick < enq_w + 7) begin
                req.cmd = abq_pkg::OP_CLR;
            end else begin
                req.cmd = abq_pkg::OP_DEQ;
            end
            send_request(req);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(7'd64,  24'hFF_FFFF, 16'hFFFF, 250, 70, 1'b0);
        random_phase(7'd4,   24'd1000,    16'd5,    200, 55, 1'b0);
        random_phase(7'd1,   24'hFF_FFFF, 16'd3,    150, 50, 1'b1);
        random_phase(7'd127, 24'd8388608, 16'd10,   200, 65, 1'b0);
        random_phase(7'd0,   24'd5000,    16'd2,    150, 50, 1'b0);
        random_phase(7'($urandom_range(1, 64)), 24'($urandom_range(1, 24'hFF_FFFF)),
                     16'($urandom_range(1, 16'hFFFF)), 200, 60, 1'b0);
        random_phase(7'd16,  24'd0,       16'd5,    80,  50, 1'b0);
        random_phase(7'd32,  24'd200000,  16'd0,    120, 60, 1'b1);
        random_phase(7'd64,  24'd1,       16'hFFFF, 150, 65, 1'b0);
        random_phase(7'($urandom_range(1, 64)), 24'($urandom_range(1, 100000)),
                     16'($urandom_range(1, 20)), 250, 60, 1'b0);
        random_phase(7'($urandom_range(0, 127)), 24'($urandom_range(0, 24'hFF_FFFF)),
                     16'($urandom_range(0, 16'hFFFF)), 250, 55, 1'b0);
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_cmd         <= abq_pkg::OP_NOP;
        i_msg_present <= 1'b0;
        i_msg_handle  <= '0;
        i_msg_bytes   <= '0;
        i_msg_stamp   <= '0;
        i_now_time    <= '0;
        no_idle       = 1'b0;
        wall_time     = $urandom;
        lim_entries   = abq_pkg::RST_MAX_ENTRIES;
        lim_bytes     = abq_pkg::RST_MAX_BYTES;
        lim_age       = abq_pkg::RST_MAX_AGE;
        q_head        = '0;
        q_count       = '0;
        q_bytes       = '0;
        total_cnt     = '0;
        total_bytes   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fifo_order();
        test_null_nop_clear();
        test_oversize();
        test_aging();
        test_count_limit();
        test_zero_limits();
        test_random_traffic();
        drain_results();

        $display("sent %0d items over %0d limit settings, checked %0d result items",
                 items_sent, settings_used, results_checked);
        $display("final drop totals: %0d entries, %0d bytes, %0d mismatching fields",
                 total_cnt, total_bytes, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
hw/rtl/abq_pkg.sv
hw/rtl/abq_ctrl.sv
hw/rtl/abq_dp.sv
hw/rtl/aging_byte_budget_drop_oldest_queue_core.sv
hw/rtl/abq_chk.sv
dv/aging_byte_budget_drop_oldest_queue_core_tb.sv
